[hw/rtl/c_integer_literal_lexer_unit_defines.svh]
// Assertion macros for the C integer literal lexer.
// Included by files that carry concurrent checks; expects a clock clk and reset rst.
`ifndef C_INTEGER_LITERAL_LEXER_UNIT_DEFINES_SVH
`define C_INTEGER_LITERAL_LEXER_UNIT_DEFINES_SVH
`ifndef SYNTHESIS
`define CILEX_ASSERT_IMP(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("cilex check failed");
`define CILEX_ASSERT_NXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("cilex check failed");
`else
`define CILEX_ASSERT_IMP(label, ante, cons)
`define CILEX_ASSERT_NXT(label, ante, cons)
`endif
`endif

[hw/rtl/cilex_pkg.sv]
// Shared types, limits and character constants for the C integer literal lexer.
// No dependencies; used by every other file of the block except the defines header.
package cilex_pkg;

  localparam int INT_BITS   = 32;
  localparam int LLONG_BITS = 64;
  localparam int VALUE_BITS = 64;

  localparam logic [VALUE_BITS-1:0] ULLONG_MAX  = ~64'd0 >> (64 - LLONG_BITS);
  localparam logic [VALUE_BITS-1:0] LLONG_MAX   = ~64'd0 >> (65 - LLONG_BITS);
  localparam logic [VALUE_BITS-1:0] INT_MAX     = (64'd1 << (INT_BITS - 1)) - 64'd1;
  localparam logic [VALUE_BITS-1:0] UINT_MAX    = (64'd1 << INT_BITS) - 64'd1;
  localparam logic [VALUE_BITS-1:0] LONG32_MAX  = 64'h0000_0000_7fff_ffff;
  localparam logic [VALUE_BITS-1:0] ULONG32_MAX = 64'h0000_0000_ffff_ffff;

  // accum*10+d stays in range iff accum < DEC_LIMIT, or accum == DEC_LIMIT and d <= DEC_REM
  localparam logic [VALUE_BITS-1:0] DEC_LIMIT = ULLONG_MAX / 64'd10;
  localparam logic [3:0]            DEC_REM   = 4'(ULLONG_MAX % 64'd10);

  localparam logic [7:0] CH_0  = 8'h30;
  localparam logic [7:0] CH_8  = 8'h38;
  localparam logic [7:0] CH_9  = 8'h39;
  localparam logic [7:0] CH_UA = 8'h41;
  localparam logic [7:0] CH_UF = 8'h46;
  localparam logic [7:0] CH_LA = 8'h61;
  localparam logic [7:0] CH_LF = 8'h66;
  localparam logic [7:0] CH_UL = 8'h4c;
  localparam logic [7:0] CH_LL = 8'h6c;
  localparam logic [7:0] CH_UU = 8'h55;
  localparam logic [7:0] CH_LU = 8'h75;
  localparam logic [7:0] CH_UX = 8'h58;
  localparam logic [7:0] CH_LX = 8'h78;
  localparam logic [7:0] CASE_MASK = 8'h5f;

  typedef enum logic [1:0] {
    PH_FIRST,
    PH_ZERO,
    PH_DIGITS,
    PH_SUFFIX
  } phase_t;

  typedef enum logic [1:0] {
    RADIX_DEC,
    RADIX_OCT,
    RADIX_HEX
  } radix_t;

  typedef enum logic [2:0] {
    T_INT,
    T_UINT,
    T_LONG,
    T_ULONG,
    T_LLONG,
    T_ULLONG
  } type_code_t;

  typedef struct packed {
    logic [7:0] token_char;
    logic       last_char;
  } in_beat_t;

  typedef struct packed {
    logic [VALUE_BITS-1:0] value;
    logic [2:0]            type_code;
    logic                  overflow_error;
    logic                  octal_error;
  } out_beat_t;

  // finished token handed from the scanner to the type classifier
  typedef struct packed {
    logic [VALUE_BITS-1:0] accum;
    radix_t                radix;
    logic                  overflow_seen;
    logic                  bad_octal_seen;
    logic [2:0][7:0]       suffix;
  } token_snap_t;

  function automatic logic is_u(input logic [7:0] c);
    return (c == CH_LU) || (c == CH_UU);
  endfunction

  function automatic logic is_l(input logic [7:0] c);
    return (c == CH_LL) || (c == CH_UL);
  endfunction

endpackage

[hw/rtl/cilex_stream_if.sv]
// Valid/ready stream interfaces for the character input and the result output.
// Depends on cilex_pkg for the beat payload types.
interface cilex_in_if import cilex_pkg::*; ();
  logic     valid;
  logic     ready;
  in_beat_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface cilex_out_if import cilex_pkg::*; ();
  logic      valid;
  logic      ready;
  out_beat_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

[hw/rtl/c_integer_literal_lexer_unit.sv]
// C integer literal lexer: takes one character per cycle, back to back across token
// boundaries unless a full snapshot waits on a stalled result, and returns value, C type and
// error flags via the snapshot and result registers after the beat that carries the last mark.
// The rate is set by the digit accumulate step in cilex_core (a 64-bit times-ten add and its
// overflow compare); type selection runs in the following register stage. The result and
// snapshot registers let new characters flow while a result waits to be taken. long_is_wide
// resets to 1; the user writes it through cfg_we/cfg_wdata only while idle, unchecked by the block.
module c_integer_literal_lexer_unit import cilex_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic        cfg_wdata,
  cilex_in_if.sink    tok,
  cilex_out_if.source res
);

`include "c_integer_literal_lexer_unit_defines.svh"

  logic        long_is_wide;
  logic        snap_valid, snap_ready;
  token_snap_t snap;

  always_ff @(posedge clk) begin
    if (rst) begin
      long_is_wide <= 1'b1;
    end else if (cfg_we) begin
      long_is_wide <= cfg_wdata;
    end
  end

  cilex_core u_core (
    .clk        (clk),
    .rst        (rst),
    .tok        (tok),
    .snap_valid (snap_valid),
    .snap_ready (snap_ready),
    .snap       (snap)
  );

  cilex_classify u_classify (
    .clk          (clk),
    .rst          (rst),
    .long_is_wide (long_is_wide),
    .snap_valid   (snap_valid),
    .snap_ready   (snap_ready),
    .snap         (snap),
    .res          (res)
  );

  // a full snapshot behind a stalled result must hold off new characters
  `CILEX_ASSERT_IMP(a_stall_blocks_input, snap_valid && res.valid && !res.ready, !tok.ready)
  `CILEX_ASSERT_NXT(a_last_makes_snap, tok.valid && tok.ready && tok.data.last_char, snap_valid)
  `CILEX_ASSERT_IMP(a_int_in_range, res.valid && res.data.type_code == T_INT, res.data.value <= INT_MAX)
  `CILEX_ASSERT_IMP(a_uint_in_range, res.valid && res.data.type_code == T_UINT, res.data.value <= UINT_MAX)

endmodule

[hw/rtl/cilex_core.sv]
// Character scanner: prefix/base detection, digit accumulation with overflow
// test, suffix capture. Hands a token snapshot on the last character. Uses cilex_pkg.
module cilex_core import cilex_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  cilex_in_if.sink    tok,
  output logic        snap_valid,
  input  logic        snap_ready,
  output token_snap_t snap
);

  phase_t                phase, phase_next;
  radix_t                radix, radix_next;
  logic [VALUE_BITS-1:0] accum, accum_next;
  logic                  overflow_seen, overflow_seen_next;
  logic                  bad_octal_seen, bad_octal_seen_next;
  logic [2:0][7:0]       suffix, suffix_next;
  logic [1:0]            suffix_count, suffix_count_next;

  logic       accept;
  logic [7:0] c;
  logic       c_dec, c_hex_alpha, do_feed, digit_ok;
  radix_t     eff_radix;
  logic [3:0] d;
  logic [7:0] hex_alpha_val;

  assign accept    = tok.valid && tok.ready;
  assign tok.ready = !snap_valid || snap_ready;
  assign c         = tok.data.token_char;

  assign c_dec         = (c >= CH_0) && (c <= CH_9);
  assign c_hex_alpha   = ((c >= CH_LA) && (c <= CH_LF)) || ((c >= CH_UA) && (c <= CH_UF));
  assign hex_alpha_val = (c & CASE_MASK) - CH_UA + 8'd10;

  always_comb begin
    phase_next          = phase;
    radix_next          = radix;
    accum_next          = accum;
    overflow_seen_next  = overflow_seen;
    bad_octal_seen_next = bad_octal_seen;
    suffix_next         = suffix;
    suffix_count_next   = suffix_count;
    do_feed             = 1'b0;
    eff_radix           = radix;
    digit_ok            = 1'b0;
    d                   = c_dec ? 4'(c - CH_0) : hex_alpha_val[3:0];

    unique case (phase)
      PH_FIRST: begin
        if (c == CH_0) begin
          radix_next = RADIX_OCT;
          phase_next = PH_ZERO;
        end else begin
          radix_next = RADIX_DEC;
          eff_radix  = RADIX_DEC;
          do_feed    = 1'b1;
        end
      end
      PH_ZERO: begin
        if (c == CH_LX || c == CH_UX) begin
          radix_next = RADIX_HEX;
          phase_next = PH_DIGITS;
        end else begin
          do_feed = 1'b1;
        end
      end
      PH_DIGITS: do_feed = 1'b1;
      PH_SUFFIX: ;
      default: ;
    endcase

    digit_ok = do_feed && ((eff_radix == RADIX_HEX) ? (c_dec || c_hex_alpha) : c_dec);

    if (digit_ok) begin
      phase_next = PH_DIGITS;
      unique case (eff_radix)
        RADIX_HEX: begin
          if (|accum[VALUE_BITS-1 -: 4]) overflow_seen_next = 1'b1;
          else accum_next = {accum[VALUE_BITS-5:0], 4'b0} + VALUE_BITS'(d);
        end
        RADIX_OCT: begin
          if (c == CH_8 || c == CH_9) bad_octal_seen_next = 1'b1;
          if (|accum[VALUE_BITS-1 -: 3]) overflow_seen_next = 1'b1;
          else accum_next = {accum[VALUE_BITS-4:0], 3'b0} + VALUE_BITS'(d);
        end
        default: begin
          if (accum > DEC_LIMIT || (accum == DEC_LIMIT && d > DEC_REM)) begin
            overflow_seen_next = 1'b1;
          end else begin
            accum_next = {accum[VALUE_BITS-4:0], 3'b0} + {accum[VALUE_BITS-2:0], 1'b0}
                         + VALUE_BITS'(d);
          end
        end
      endcase
    end else if (do_feed || phase == PH_SUFFIX) begin
      // suffix character; only the first three are kept
      phase_next = PH_SUFFIX;
      if (suffix_count != 2'd3) begin
        for (int i = 0; i < 3; i++) begin
          if (suffix_count == 2'(i)) suffix_next[i] = c;
        end
        suffix_count_next = suffix_count + 2'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase          <= PH_FIRST;
      radix          <= RADIX_DEC;
      accum          <= '0;
      overflow_seen  <= 1'b0;
      bad_octal_seen <= 1'b0;
      suffix         <= '0;
      suffix_count   <= 2'd0;
    end else if (accept) begin
      if (tok.data.last_char) begin
        phase          <= PH_FIRST;
        radix          <= RADIX_DEC;
        accum          <= '0;
        overflow_seen  <= 1'b0;
        bad_octal_seen <= 1'b0;
        suffix         <= '0;
        suffix_count   <= 2'd0;
      end else begin
        phase          <= phase_next;
        radix          <= radix_next;
        accum          <= accum_next;
        overflow_seen  <= overflow_seen_next;
        bad_octal_seen <= bad_octal_seen_next;
        suffix         <= suffix_next;
        suffix_count   <= suffix_count_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      snap_valid <= 1'b0;
    end else if (accept && tok.data.last_char) begin
      snap_valid <= 1'b1;
    end else if (snap_ready) begin
      snap_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept && tok.data.last_char) begin
      snap.accum          <= accum_next;
      snap.radix          <= radix_next;
      snap.overflow_seen  <= overflow_seen_next;
      snap.bad_octal_seen <= bad_octal_seen_next;
      snap.suffix         <= suffix_next;
    end
  end

endmodule

[hw/rtl/cilex_classify.sv]
// Type selection from suffix, base and type limits; drives the result register.
// Uses cilex_pkg; fed by cilex_core.
module cilex_classify import cilex_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        long_is_wide,
  input  logic        snap_valid,
  output logic        snap_ready,
  input  token_snap_t snap,
  cilex_out_if.source res
);

  logic [7:0]            s0, s1, s2;
  logic [VALUE_BITS-1:0] n, long_max, ulong_max;
  logic                  dec, ll, ull, llu, lu, ul;
  logic                  gt_int, gt_uint, gt_long, gt_ulong, gt_llong;
  logic                  is_signed;
  type_code_t            ty;

  assign s0  = snap.suffix[0];
  assign s1  = snap.suffix[1];
  assign s2  = snap.suffix[2];
  assign n   = snap.accum;
  assign dec = (snap.radix == RADIX_DEC);

  assign ll  = (s0 == CH_LL && s1 == CH_LL) || (s0 == CH_UL && s1 == CH_UL);
  assign ull = is_u(s0) && ((s1 == CH_LL && s2 == CH_LL) || (s1 == CH_UL && s2 == CH_UL));
  assign llu = ll && is_u(s2);
  assign lu  = is_l(s0) && is_u(s1);
  assign ul  = is_u(s0) && is_l(s1);

  assign long_max  = long_is_wide ? LLONG_MAX : LONG32_MAX;
  assign ulong_max = long_is_wide ? ULLONG_MAX : ULONG32_MAX;

  assign gt_int   = n > INT_MAX;
  assign gt_uint  = n > UINT_MAX;
  assign gt_long  = n > long_max;
  assign gt_ulong = n > ulong_max;
  assign gt_llong = n > LLONG_MAX;

  always_comb begin
    priority if (ull || llu) begin
      ty = T_ULLONG;
    end else if (ll) begin
      ty = (gt_llong && !dec) ? T_ULLONG : T_LLONG;
    end else if (lu || ul) begin
      ty = gt_ulong ? T_ULLONG : T_ULONG;
    end else if (is_l(s0)) begin
      priority if (dec)      ty = gt_long ? T_LLONG : T_LONG;
      else if (!gt_long)     ty = T_LONG;
      else if (!gt_ulong)    ty = T_ULONG;
      else if (!gt_llong)    ty = T_LLONG;
      else                   ty = T_ULLONG;
    end else if (is_u(s0)) begin
      priority if (!gt_uint) ty = T_UINT;
      else if (!gt_ulong)    ty = T_ULONG;
      else                   ty = T_ULLONG;
    end else if (dec) begin
      priority if (!gt_int)  ty = T_INT;
      else if (!gt_long)     ty = T_LONG;
      else                   ty = T_LLONG;
    end else begin
      priority if (!gt_int)  ty = T_INT;
      else if (!gt_uint)     ty = T_UINT;
      else if (!gt_long)     ty = T_LONG;
      else if (!gt_ulong)    ty = T_ULONG;
      else if (!gt_llong)    ty = T_LLONG;
      else                   ty = T_ULLONG;
    end
  end

  assign is_signed  = (ty == T_INT) || (ty == T_LONG) || (ty == T_LLONG);
  assign snap_ready = !res.valid || res.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      res.valid <= 1'b0;
    end else if (snap_ready) begin
      res.valid <= snap_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (snap_ready && snap_valid) begin
      res.data.value          <= n;
      res.data.type_code      <= ty;
      res.data.overflow_error <= snap.overflow_seen || (is_signed && gt_llong);
      res.data.octal_error    <= snap.bad_octal_seen;
    end
  end

endmodule
